// File: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants for the infix-to-postfix converter
// Character codes, operator ranking functions and the emit bundle passed
// from the sequencer to the output register.
// ----------------------------------------------------------------------------
package itp_pkg;

   // Character codes
   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_STAR  = 8'h2A;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_CARET = 8'h5E;

   typedef logic [2:0] rank_type;

   // One result transaction produced by the sequencer
   typedef struct packed {
      logic       valid;
      logic [7:0] char_out;
      logic       last;
      logic       overflow;
   } emit_type;

   function automatic logic is_operator(input logic [7:0] c);
      return (c == CHAR_PLUS) || (c == CHAR_MINUS) || (c == CHAR_STAR) ||
             (c == CHAR_SLASH) || (c == CHAR_CARET);
   endfunction

   // Precedence of an operator arriving at the input
   function automatic rank_type incoming_rank(input logic [7:0] c);
      rank_type r;
      if (c == CHAR_CARET)                           r = 3'd4;
      else if ((c == CHAR_STAR) || (c == CHAR_SLASH)) r = 3'd2;
      else                                            r = 3'd1;
      return r;
   endfunction

   // Precedence of an operator sitting on the stack (^ lower: right assoc)
   function automatic rank_type stacked_rank(input logic [7:0] c);
      rank_type r;
      if (c == CHAR_CARET)                           r = 3'd3;
      else if ((c == CHAR_STAR) || (c == CHAR_SLASH)) r = 3'd2;
      else                                            r = 3'd1;
      return r;
   endfunction

endpackage

// File: rtl/itp_ram.sv
// ----------------------------------------------------------------------------
// itp_ram: generic single-write, single-read synchronous RAM
// Read data is registered and holds while rd_en is low.
// ----------------------------------------------------------------------------
module itp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/itp_ctrl.sv
// ----------------------------------------------------------------------------
// itp_ctrl: shunting-yard sequencer
// Accepts one character, reads the stack top from RAM, and emits one result
// per cycle while popping and the result slot is free, pushing the new operator at the end.
// ----------------------------------------------------------------------------
module itp_ctrl #(
   parameter int STACK_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic [7:0]                     req_char_in,
   output logic                           req_stall,
   input  logic                           out_free,
   output itp_pkg::emit_type              emit,
   output logic                           wr_en,
   output logic [$clog2(STACK_DEPTH)-1:0] wr_addr,
   output logic [7:0]                     wr_data,
   output logic                           rd_en,
   output logic [$clog2(STACK_DEPTH)-1:0] rd_addr,
   input  logic [7:0]                     rd_data
);

   localparam int CntW  = $clog2(STACK_DEPTH + 1);
   localparam int AddrW = $clog2(STACK_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LEAD = 2'd1;  // stack top valid on rd_data
   localparam logic [1:0] S_POP  = 2'd2;  // emit popped operator

   logic [1:0]      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [7:0]      cur_ff, cur_in;
   logic [7:0]      top_ff, top_in;
   logic            has_top;
   logic            full;
   logic            do_pop;

   assign has_top = (count_ff != '0);
   assign full    = (count_ff == CntW'(STACK_DEPTH));
   assign do_pop  = has_top && (itp_pkg::incoming_rank(cur_ff) <=
                                itp_pkg::stacked_rank(rd_data));

   // Sequencer next-state logic
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      cur_in    = cur_ff;
      top_in    = top_ff;
      emit      = '0;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AddrW-1:0];
      wr_data   = cur_ff;
      req_stall = !((state_ff == S_IDLE) && out_free);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cur_in = req_char_in;
               if ((req_char_in == itp_pkg::CHAR_NUL) ||
                   itp_pkg::is_operator(req_char_in)) begin
                  state_in = S_LEAD;
               end else begin
                  emit = '{valid: 1'b1, char_out: req_char_in, last: 1'b1,
                           overflow: 1'b0};
               end
            end
         end
         S_LEAD: begin
            if (out_free) begin
               if (cur_ff == itp_pkg::CHAR_NUL) begin
                  // End of expression: flush as space, operator pairs
                  if (has_top) begin
                     emit = '{valid: 1'b1, char_out: itp_pkg::CHAR_SPACE,
                              last: 1'b0, overflow: 1'b0};
                     top_in   = rd_data;
                     state_in = S_POP;
                  end else begin
                     emit = '{valid: 1'b1, char_out: itp_pkg::CHAR_NUL,
                              last: 1'b1, overflow: 1'b0};
                     state_in = S_IDLE;
                  end
               end else begin
                  // Operator: space, then pop while top ranks at least as high
                  emit = '{valid: 1'b1, char_out: itp_pkg::CHAR_SPACE,
                           last: !do_pop, overflow: !do_pop && full};
                  if (do_pop) begin
                     top_in   = rd_data;
                     state_in = S_POP;
                  end else begin
                     if (!full) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     state_in = S_IDLE;
                  end
               end
            end
         end
         S_POP: begin
            if (out_free) begin
               emit = '{valid: 1'b1, char_out: top_ff, last: 1'b0,
                        overflow: 1'b0};
               count_in = count_ff - 1'b1;
               state_in = S_LEAD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Fetch the new top whenever the sequencer enters S_LEAD with a non-empty stack
   assign rd_en   = (state_in == S_LEAD) && (state_ff != S_LEAD) && (count_in != '0);
   assign rd_addr = count_in[AddrW-1:0] - 1'b1;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      top_ff <= top_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(STACK_DEPTH))
      else $error("stack count exceeds depth");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CntW'(STACK_DEPTH)))
      else $error("push onto full stack");

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> req_stall)
      else $error("input accepted while busy");

   a_overflow_last: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.overflow) |-> emit.last)
      else $error("overflow flagged on non-final result");

   a_pop_needs_top: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_POP) |-> (count_ff != '0))
      else $error("pop from empty stack");

endmodule

// File: rtl/infix_to_postfix_converter_core.sv
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_core: streaming infix-to-postfix converter
// Operator stack in a synchronous RAM, sequencer and output register.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one expression byte per transaction; a zero byte closes
//   the expression. rsp_* returns postfix bytes, one per transaction; rsp_last
//   marks the final result of each input byte and rsp_overflow flags an
//   operator dropped because the stack was full.
// Timing:
//   An operand byte's result appears the cycle after it is accepted.
//   An operator emits a space, then the popped operator and a space for each
//   pop; the end byte emits a space and an operator per stacked operator, then
//   the zero byte. Each pop emits two results, one per cycle while the result
//   slot is free; the registered RAM read of the next stack top overlaps the
//   cycle that emits the popped operator. One byte is worked on at a time.
// Reset: synchronous; the stack is emptied and no result is pending.
// Stall: rsp_stall holds the output register; the sequencer freezes and
//   req_stall stays high until the result slot frees up.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter_core #(
   parameter int STACK_DEPTH = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_char_out,
   output logic       rsp_last,
   output logic       rsp_overflow
);

   localparam int AddrW = $clog2(STACK_DEPTH);

   itp_pkg::emit_type emit;
   logic              out_free;
   logic              wr_en;
   logic [AddrW-1:0]  wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [AddrW-1:0]  rd_addr;
   logic [7:0]        rd_data;

   logic              rsp_valid_ff;
   logic [7:0]        rsp_char_ff;
   logic              rsp_last_ff;
   logic              rsp_overflow_ff;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   itp_ctrl #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_char_in(req_char_in),
      .req_stall  (req_stall),
      .out_free   (out_free),
      .emit       (emit),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data)
   );

   itp_ram #(
      .WIDTH(8),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   // Output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= emit.valid;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (out_free && emit.valid) begin
         rsp_char_ff     <= emit.char_out;
         rsp_last_ff     <= emit.last;
         rsp_overflow_ff <= emit.overflow;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_overflow = rsp_overflow_ff;

   a_no_emit_when_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !emit.valid)
      else $error("result produced while output register held");

   a_accept_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> out_free)
      else $error("input accepted without free result slot");

   a_no_write_read_same: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("stack RAM read and write collide");

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for infix_to_postfix_converter_core
// Streams infix expression bytes into the converter and checks every postfix
// transaction against an operator-stack predictor kept in a scoreboard. A
// directed expression covers all operators, parentheses, the empty
// expression and a full stack. Random expressions then run through four
// phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // One expected postfix transaction
   typedef struct packed {
      logic [7:0] ch;
      logic       last;
      logic       overflow;
   } postfix_char_type;

   class postfix_scoreboard;
      localparam int STACK_SLOTS = 16;

      logic [7:0]       op_stack [STACK_SLOTS];
      int unsigned      depth;
      postfix_char_type pending [$];
      int unsigned      mismatches;
      int unsigned      results_checked;
      int unsigned      overflow_hits;
      int unsigned      expressions_closed;

      // Binding strength of an operator; 0 means the byte is an operand
      function int unsigned binding(input logic [7:0] c, input bit stacked);
         case (c)
            itp_pkg::CHAR_CARET:                      return stacked ? 3 : 4;
            itp_pkg::CHAR_STAR, itp_pkg::CHAR_SLASH:  return 2;
            itp_pkg::CHAR_PLUS, itp_pkg::CHAR_MINUS:  return 1;
            default:                                  return 0;
         endcase
      endfunction

      function void queue_char(input logic [7:0] ch);
         pending.push_back('{ch, 1'b0, 1'b0});
      endfunction

      // Work out the postfix transactions caused by one accepted input byte
      function void note_char(input logic [7:0] c);
         int unsigned strength;
         strength = binding(c, 1'b0);
         if (c == itp_pkg::CHAR_NUL) begin
            // end of expression: flush the stack top down, then the terminator
            while (depth > 0) begin
               depth--;
               queue_char(itp_pkg::CHAR_SPACE);
               queue_char(op_stack[depth]);
            end
            queue_char(itp_pkg::CHAR_NUL);
            expressions_closed++;
         end else if (strength == 0) begin
            queue_char(c);
         end else begin
            queue_char(itp_pkg::CHAR_SPACE);
            while (depth > 0 && strength <= binding(op_stack[depth - 1], 1'b1)) begin
               depth--;
               queue_char(op_stack[depth]);
               queue_char(itp_pkg::CHAR_SPACE);
            end
            if (depth < STACK_SLOTS) begin
               op_stack[depth] = c;
               depth++;
            end else begin
               // push dropped: flag it on the final transaction
               pending[pending.size() - 1].overflow = 1'b1;
               overflow_hits++;
            end
         end
         pending[pending.size() - 1].last = 1'b1;
      endfunction

      task report_mismatch(input string what);
         mismatches++;
         if (mismatches <= 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
         end
      endtask

      // Compare one accepted result with the oldest expectation
      task check_result(input logic [7:0] ch, input logic last, input logic overflow);
         postfix_char_type want;
         results_checked++;
         if (pending.size() == 0) begin
            report_mismatch($sformatf("unexpected result char 0x%02h last %0b overflow %0b",
                                      ch, last, overflow));
            return;
         end
         want = pending.pop_front();
         if (ch !== want.ch || last !== want.last || overflow !== want.overflow) begin
            report_mismatch($sformatf({"result %0d: got char 0x%02h last %0b overflow %0b,",
                                       " want char 0x%02h last %0b overflow %0b"},
                                      results_checked, ch, last, overflow,
                                      want.ch, want.last, want.overflow));
         end
      endtask
   endclass

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          RANDOM_ITEMS = 370;
   localparam logic [7:0]  OPEN_PAREN   = 8'h28;
   localparam logic [7:0]  CLOSE_PAREN  = 8'h29;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_char_out;
   logic       rsp_last;
   logic       rsp_overflow;

   postfix_scoreboard scoreboard = new();

   int unsigned sent_count    = 0;
   int unsigned cycle_count   = 0;
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   infix_to_postfix_converter_core u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_char_in  (req_char_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_char_out (rsp_char_out),
      .rsp_last     (rsp_last),
      .rsp_overflow (rsp_overflow)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, scoreboard.pending.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_result(rsp_char_out, rsp_last, rsp_overflow);
      end
   end

   // Drive one byte, with random idle cycles ahead of it
   task automatic send_char(input logic [7:0] c);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      do @(posedge clock); while (req_stall);
      scoreboard.note_char(c);
      sent_count++;
      @(negedge clock);
   endtask

   // Hold the sender off until every expected result has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (scoreboard.pending.size() != 0);
   endtask

   function automatic logic [7:0] operator_byte();
      case ($urandom_range(4))
         0:       return itp_pkg::CHAR_PLUS;
         1:       return itp_pkg::CHAR_MINUS;
         2:       return itp_pkg::CHAR_STAR;
         3:       return itp_pkg::CHAR_SLASH;
         default: return itp_pkg::CHAR_CARET;
      endcase
   endfunction

   function automatic logic [7:0] operand_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (scoreboard.binding(b, 1'b0) != 0);
      return b;
   endfunction

   function automatic logic [7:0] noise_byte();
      if ($urandom_range(2) == 0) begin
         return operator_byte();
      end
      return 8'($urandom_range(255));
   endfunction

   // One random expression: mostly well formed, some noise and deep ^ chains
   task automatic emit_expression();
      int unsigned kind;
      int unsigned terms;
      int unsigned n;
      kind = $urandom_range(99);
      if (kind < 12) begin
         n = $urandom_range(1, 8);
         repeat (n) send_char(noise_byte());
      end else if (kind < 20) begin
         // right-associative chain that can run the stack full
         send_char(operand_byte());
         n = $urandom_range(12, 20);
         repeat (n) begin
            send_char(itp_pkg::CHAR_CARET);
            if ($urandom_range(1)) send_char(operand_byte());
         end
         send_char(itp_pkg::CHAR_NUL);
      end else begin
         terms = $urandom_range(1, 7);
         for (int i = 0; i <= terms; i++) begin
            if (i > 0) send_char(operator_byte());
            if ($urandom_range(5) == 0) send_char(OPEN_PAREN);
            n = $urandom_range(1, 3);
            repeat (n) send_char(operand_byte());
            if ($urandom_range(5) == 0) send_char(CLOSE_PAREN);
         end
         // occasionally leave it open so it runs into the next one
         if ($urandom_range(9) != 0) send_char(itp_pkg::CHAR_NUL);
      end
   endtask

   // Main sequence
   initial begin
      string       infix;
      int unsigned phase_base;
      infix = "(a+b)*c-d/e";

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty expression, extreme operand, all operators, full stack
      send_char(itp_pkg::CHAR_NUL);
      send_char(8'hFF);
      foreach (infix[i]) send_char(infix[i]);
      repeat (15) send_char(itp_pkg::CHAR_CARET);
      send_char(itp_pkg::CHAR_NUL);
      wait_drained();

      // random: free running, sender idle, receiver stall, both
      phase_base = sent_count;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 79; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 79; end
            default: begin send_idle_pct = 38; stall_pct = 38; end
         endcase
         while (sent_count < phase_base + RANDOM_ITEMS * (phase + 1) / 4) begin
            emit_expression();
         end
         send_char(itp_pkg::CHAR_NUL);
         wait_drained();
      end

      stall_pct = 0;
      repeat (40) @(posedge clock);

      $display("covered %0d input transactions over four idle/stall phases, %0d expressions",
               sent_count, scoreboard.expressions_closed);
      $display("checked %0d results, %0d dropped pushes, %0d mismatches",
               scoreboard.results_checked, scoreboard.overflow_hits, scoreboard.mismatches);
      if (scoreboard.mismatches == 0 && scoreboard.pending.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
